@@ design/dcrf_pkg.sv @@
package dcrf_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned NumPageRegs = 16;
  localparam int unsigned NumCtlPorts = 16;

  localparam int unsigned ChanIdxW = $clog2(NumChannels);
  localparam int unsigned PortW    = $clog2(NumCtlPorts);

  typedef logic [ChanIdxW-1:0] chan_idx_t;
  typedef logic [PortW-1:0]    port_t;
  typedef logic [7:0]          byte_t;
  typedef logic [15:0]         word16_t;
  typedef logic [NumChannels-1:0] mask_t;

  localparam logic OpRead    = 1'b0;
  localparam logic OpWrite   = 1'b1;
  localparam logic SpaceCtl  = 1'b0;
  localparam logic SpacePage = 1'b1;

  // controller port codes above the channel address/count ports
  localparam port_t PortCommand  = 4'd8;
  localparam port_t PortStatus   = 4'd8;
  localparam port_t PortRequest  = 4'd9;
  localparam port_t PortSglMask  = 4'd10;
  localparam port_t PortMode     = 4'd11;
  localparam port_t PortClearFf  = 4'd12;
  localparam port_t PortMstClear = 4'd13;
  localparam port_t PortClrMask  = 4'd14;
  localparam port_t PortAllMask  = 4'd15;

  typedef struct packed {
    logic  op;
    logic  space;
    port_t port;
    byte_t wdata;
  } req_t;

  typedef struct packed {
    byte_t rdata;
    mask_t mask_bits;
    logic  byte_pointer;
    byte_t command_value;
  } rsp_t;

  function automatic word16_t put_byte(word16_t v, byte_t b, logic high);
    word16_t r;
    if (high) begin
      r = {b, v[7:0]};
    end else begin
      r = {v[15:8], b};
    end
    return r;
  endfunction

endpackage

@@ design/dcrf_if.sv @@
interface dcrf_req_if;
  import dcrf_pkg::*;

  logic  valid;
  logic  ready;
  logic  op;
  logic  space;
  port_t port;
  byte_t wdata;

  modport source (output valid, output op, output space, output port, output wdata,
                  input ready);
  modport sink   (input valid, input op, input space, input port, input wdata,
                  output ready);
endinterface

interface dcrf_rsp_if;
  import dcrf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rdata;
  mask_t mask_bits;
  logic  byte_pointer;
  byte_t command_value;

  modport source (output valid, output rdata, output mask_bits, output byte_pointer,
                  output command_value, input ready);
  modport sink   (input valid, input rdata, input mask_bits, input byte_pointer,
                  input command_value, output ready);
endinterface

@@ design/dcrf_core.sv @@
module dcrf_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dcrf_pkg::req_t req_i,
  output dcrf_pkg::rsp_t rsp_o
);
  import dcrf_pkg::*;

  word16_t addr_q [NumChannels];
  word16_t addr_d [NumChannels];
  word16_t cnt_q  [NumChannels];
  word16_t cnt_d  [NumChannels];
  byte_t   mode_q [NumChannels];
  byte_t   mode_d [NumChannels];
  byte_t   lw_q   [NumCtlPorts];
  byte_t   lw_d   [NumCtlPorts];
  byte_t   page_q [NumPageRegs];
  byte_t   page_d [NumPageRegs];
  logic    flip_q, flip_d;
  mask_t   mask_q, mask_d;
  byte_t   cmd_q, cmd_d;

  chan_idx_t ch;
  logic      chan_sel;
  logic      flip_t;
  word16_t   rd_val;
  byte_t     rdata;

  assign ch       = req_i.port[ChanIdxW:1];
  assign chan_sel = ~req_i.port[PortW-1];
  assign flip_t   = ~flip_q;
  assign rd_val   = req_i.port[0] ? cnt_q[ch] : addr_q[ch];

  always_comb begin
    addr_d = addr_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    lw_d   = lw_q;
    page_d = page_q;
    flip_d = flip_q;
    mask_d = mask_q;
    cmd_d  = cmd_q;
    rdata  = '0;
    if (req_i.space == SpacePage) begin
      if (req_i.op == OpWrite) begin
        page_d[req_i.port] = req_i.wdata;
      end else begin
        rdata = page_q[req_i.port];
      end
    end else if (req_i.op == OpWrite) begin
      lw_d[req_i.port] = req_i.wdata;
      if (chan_sel) begin
        flip_d = flip_t;
        if (req_i.port[0]) begin
          cnt_d[ch] = put_byte(cnt_q[ch], req_i.wdata, ~flip_t);
        end else begin
          addr_d[ch] = put_byte(addr_q[ch], req_i.wdata, ~flip_t);
        end
      end else begin
        unique case (req_i.port)
          PortCommand:  cmd_d = req_i.wdata;
          PortSglMask:  mask_d[req_i.wdata[ChanIdxW-1:0]] = req_i.wdata[2];
          PortMode:     mode_d[req_i.wdata[ChanIdxW-1:0]] = req_i.wdata;
          PortClearFf:  flip_d = 1'b0;
          PortMstClear: begin
            flip_d = 1'b0;
            mask_d = '1;
          end
          PortAllMask:  mask_d = req_i.wdata[NumChannels-1:0];
          default: ;
        endcase
      end
    end else begin
      if (chan_sel) begin
        flip_d = flip_t;
        rdata  = flip_t ? rd_val[7:0] : rd_val[15:8];
      end else if (req_i.port == PortStatus || req_i.port == PortMstClear) begin
        rdata = '0;
      end else begin
        rdata = lw_q[req_i.port];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        addr_q[i] <= '0;
        cnt_q[i]  <= '0;
        mode_q[i] <= '0;
      end
      for (int i = 0; i < NumCtlPorts; i++) begin
        lw_q[i] <= '0;
      end
      for (int i = 0; i < NumPageRegs; i++) begin
        page_q[i] <= '0;
      end
      flip_q <= 1'b0;
      mask_q <= '0;
      cmd_q  <= '0;
    end else if (en_i) begin
      addr_q <= addr_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      lw_q   <= lw_d;
      page_q <= page_d;
      flip_q <= flip_d;
      mask_q <= mask_d;
      cmd_q  <= cmd_d;
    end
  end

  assign rsp_o.rdata         = rdata;
  assign rsp_o.mask_bits     = mask_d;
  assign rsp_o.byte_pointer  = flip_d;
  assign rsp_o.command_value = cmd_d;

  a_mclr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.space == SpaceCtl && req_i.op == OpWrite && req_i.port == PortMstClear
    |=> mask_q == '1 && !flip_q)
    else $error("master clear did not set mask and clear byte pointer");

  a_page_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.space == SpacePage |=> flip_q == $past(flip_q))
    else $error("page access moved byte pointer");

  a_chan_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.space == SpaceCtl && !req_i.port[PortW-1] |=> flip_q != $past(flip_q))
    else $error("channel port access did not toggle byte pointer");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.space == SpaceCtl && req_i.op == OpWrite && req_i.port == PortMode
    |=> mode_q[$past(req_i.wdata[ChanIdxW-1:0])] == $past(req_i.wdata))
    else $error("mode write not stored");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(mask_q) && $stable(flip_q) && $stable(cmd_q))
    else $error("control state changed without an access");

endmodule

@@ design/dma_controller_register_file.sv @@
// Register side of a four-channel 8237-style DMA controller.
// req_i carries one bus access per word: op (read/write), space (controller
// or page ports), port and wdata. rsp_o returns exactly one word per access:
// rdata (zero on writes) plus the mask bits, byte pointer and command
// register as they stand after the access.
// An access accepted on req_i is loaded into the input register; decode/update
// then updates state and fills the result register that drives rsp_o.
// Throughput: one access per cycle unless rsp_o.ready stalls; state is read
// and updated between the input register and the result register.
// Reset clears all channel registers, modes, mask, command, byte pointer,
// the written-byte shadow and the page store; both pipeline stages empty.
// When the receiver holds rsp_o.ready low, the result register and the input
// register hold, and req_i.ready drops once both are full.
module dma_controller_register_file (
  input  logic clk_i,
  input  logic rst_ni,
  dcrf_req_if.sink   req_i,
  dcrf_rsp_if.source rsp_o
);
  import dcrf_pkg::*;

  logic s1_valid_q, s1_valid_d;
  req_t s1_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;
  rsp_t core_rsp;
  logic adv, proc, take;

  assign adv         = !out_valid_q || rsp_o.ready;
  assign proc        = s1_valid_q && adv;
  assign req_i.ready = !s1_valid_q || adv;
  assign take        = req_i.valid && req_i.ready;

  assign s1_valid_d  = take || (s1_valid_q && !adv);
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  dcrf_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (proc),
    .req_i (s1_q),
    .rsp_o (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= '{op: req_i.op, space: req_i.space, port: req_i.port, wdata: req_i.wdata};
    end
    if (proc) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.rdata         = out_q.rdata;
  assign rsp_o.mask_bits     = out_q.mask_bits;
  assign rsp_o.byte_pointer  = out_q.byte_pointer;
  assign rsp_o.command_value = out_q.command_value;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_q))
    else $error("pending access lost under stall");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed access produced no result");

endmodule
